@@ sv/kthc_pkg.sv @@
package kthc_pkg;

  // Largest supported key count and the fixed index of the polled key
  localparam int unsigned MAX_KEYS   = 5;
  localparam int unsigned KEY_IDX_W  = 3;
  localparam logic [KEY_IDX_W-1:0] POLLED_KEY = 3'd4;

  // Configuration register width and indexes
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_RELEASE = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [CFG_W-1:0] TAP_LIMIT_RST    = 16'd300;
  localparam logic [CFG_W-1:0] AUTO_RELEASE_RST = 16'd2000;

  // Request types
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_POLL  = 1'b1;

  // Per-key result codes
  localparam logic [1:0] RES_NONE = 2'd0;
  localparam logic [1:0] RES_TAP  = 2'd1;
  localparam logic [1:0] RES_HOLD = 2'd2;

  typedef enum logic [1:0] {
    PH_START    = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2,
    PH_RELEASED = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_POLL,
    ST_CLASSIFY,
    ST_RELEASE,
    ST_DONE
  } state_e;

  // Write strobes into the time store; clr writes zero instead of the request time
  typedef struct packed {
    logic rise_we;
    logic rise_clr;
    logic fall_we;
    logic fall_clr;
    logic rel_we;
  } store_wr_t;

  // Flags from the shared subtract/compare unit
  typedef struct packed {
    logic neg;
    logic gt_a;
    logic lt_b;
  } alu_flags_t;

endpackage

@@ sv/kthc_alu.sv @@
module kthc_alu
  import kthc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0] op_a_i,
  input  logic [TIME_BITS-1:0] op_b_i,
  input  logic [CFG_W-1:0]     thr_a_i,
  input  logic [CFG_W-1:0]     thr_b_i,
  output alu_flags_t           flags_o
);

  logic [TIME_BITS-1:0] diff;

  // wrap-around difference, then one compare against each threshold
  assign diff          = op_a_i - op_b_i;
  assign flags_o.neg   = diff[TIME_BITS-1];
  assign flags_o.gt_a  = diff > TIME_BITS'(thr_a_i);
  assign flags_o.lt_b  = diff < TIME_BITS'(thr_b_i);

endmodule

@@ sv/kthc_store.sv @@
module kthc_store
  import kthc_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 5,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_IDX_W-1:0] idx_i,
  input  store_wr_t            wr_i,
  input  logic [TIME_BITS-1:0] now_i,
  output logic [TIME_BITS-1:0] rise_o,
  output logic [TIME_BITS-1:0] fall_o,
  output logic [TIME_BITS-1:0] rel_o
);

  localparam int unsigned IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  logic [TIME_BITS-1:0] rise_q [KEY_COUNT];
  logic [TIME_BITS-1:0] fall_q [KEY_COUNT];
  logic [TIME_BITS-1:0] rel_q  [KEY_COUNT];
  logic                 sel_ok;
  logic [IDX_W-1:0]     sel;

  assign sel_ok = 32'(idx_i) < KEY_COUNT;
  assign sel    = idx_i[IDX_W-1:0];

  assign rise_o = sel_ok ? rise_q[sel] : '0;
  assign fall_o = sel_ok ? fall_q[sel] : '0;
  assign rel_o  = sel_ok ? rel_q[sel]  : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        rise_q[k] <= '0;
        fall_q[k] <= '0;
        rel_q[k]  <= '0;
      end
    end else if (sel_ok) begin
      if (wr_i.rise_we) begin
        rise_q[sel] <= wr_i.rise_clr ? '0 : now_i;
      end
      if (wr_i.fall_we) begin
        fall_q[sel] <= wr_i.fall_clr ? '0 : now_i;
      end
      if (wr_i.rel_we) begin
        rel_q[sel] <= now_i;
      end
    end
  end

endmodule

@@ sv/key_tap_hold_classifier.sv @@
// Tap/hold classifier for up to five keys. A level-change request for keys
// 0-3 holds the block in the event state, which updates the store, and
// returns nothing. A poll request runs the key 4 detector (when KEY_COUNT is
// 5), then walks every key through one shared subtract-and-compare unit: one
// step classifies the stored press, the next checks auto-release. The done
// state then yields one result with a code per key; the detector step is
// skipped below five keys. The per-key time store is read at the sequencer's
// key index. The input is ready again only when the sequencer is back in
// idle; a finished result waits in an output register and does not hold off new
// requests unless a second poll finishes before the first result is taken.
// Configuration is to be written through cfg_we_i/cfg_addr_i/cfg_wdata_i only
// while idle; the block itself does not enforce this.
module key_tap_hold_classifier
  import kthc_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 5,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [1:0]           key_index_i,
  input  logic                 key_level_i,
  input  logic [31:0]          now_ms_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           state_key0_o,
  output logic [1:0]           state_key1_o,
  output logic [1:0]           state_key2_o,
  output logic [1:0]           state_key3_o,
  output logic [1:0]           state_key4_o
);

  // configuration registers
  logic [CFG_W-1:0] deb_q, tap_q, auto_q;

  // sequencer
  state_e               state_q, state_d;
  logic [KEY_IDX_W-1:0] idx_q, idx_d;
  phase_e               phase_q, phase_d;

  // request payload held for the duration of the walk
  logic                 level_q;
  logic [TIME_BITS-1:0] now_q;

  // per-key results being built and the output register
  logic [1:0] acc_q [MAX_KEYS];
  logic [1:0] acc_d [MAX_KEYS];
  logic [1:0] res_q [MAX_KEYS];
  logic [1:0] res_d [MAX_KEYS];
  logic       out_valid_q, out_valid_d;

  // shared unit and store hookup
  store_wr_t            wr;
  logic [TIME_BITS-1:0] rise_rd, fall_rd, rel_rd;
  logic [TIME_BITS-1:0] alu_a, alu_b;
  logic [CFG_W-1:0]     thr_a, thr_b;
  alu_flags_t           flags;
  logic                 last_key;
  logic                 key_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign last_key   = (idx_q == KEY_IDX_W'(KEY_COUNT - 1));
  assign key_ok     = 32'(idx_q) < KEY_COUNT;

  kthc_store #(
    .KEY_COUNT(KEY_COUNT),
    .TIME_BITS(TIME_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (idx_q),
    .wr_i   (wr),
    .now_i  (now_q),
    .rise_o (rise_rd),
    .fall_o (fall_rd),
    .rel_o  (rel_rd)
  );

  kthc_alu #(
    .TIME_BITS(TIME_BITS)
  ) u_alu (
    .op_a_i  (alu_a),
    .op_b_i  (alu_b),
    .thr_a_i (thr_a),
    .thr_b_i (thr_b),
    .flags_o (flags)
  );

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= DEBOUNCE_RST;
      tap_q  <= TAP_LIMIT_RST;
      auto_q <= AUTO_RELEASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DEBOUNCE:     deb_q  <= cfg_wdata_i;
        REG_TAP_LIMIT:    tap_q  <= cfg_wdata_i;
        REG_AUTO_RELEASE: auto_q <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      phase_q     <= PH_START;
      out_valid_q <= 1'b0;
      for (int k = 0; k < MAX_KEYS; k++) begin
        acc_q[k] <= RES_NONE;
        res_q[k] <= RES_NONE;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      res_q       <= res_d;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      level_q <= key_level_i;
      now_q   <= TIME_BITS'(now_ms_i);
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr          = '0;
    alu_a       = now_q;
    alu_b       = rise_rd;
    thr_a       = deb_q;
    thr_b       = tap_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_POLL) begin
            for (int k = 0; k < MAX_KEYS; k++) begin
              acc_d[k] = RES_NONE;
            end
            if (KEY_COUNT == MAX_KEYS) begin
              state_d = ST_POLL;
              idx_d   = POLLED_KEY;
            end else begin
              state_d = ST_CLASSIFY;
              idx_d   = '0;
            end
          end else begin
            state_d = ST_EVENT;
            idx_d   = {1'b0, key_index_i};
          end
        end
      end

      // rise recorded once, fall only after a rise
      ST_EVENT: begin
        if (key_ok) begin
          if (level_q && rise_rd == '0) begin
            wr.rise_we = 1'b1;
            wr.rel_we  = 1'b1;
          end else if (!level_q && rise_rd != '0) begin
            wr.fall_we = 1'b1;
          end
        end
        state_d = ST_IDLE;
      end

      // key 4 detector: age of the rise against debounce or auto-release
      ST_POLL: begin
        thr_a = (phase_q == PH_DEBOUNCE) ? deb_q : auto_q;
        if (level_q) begin
          unique case (phase_q)
            PH_START: begin
              wr.rise_we = 1'b1;
              wr.rel_we  = 1'b1;
              phase_d    = PH_DEBOUNCE;
            end
            PH_DEBOUNCE: begin
              if (flags.gt_a) begin
                phase_d = PH_HELD;
              end
            end
            PH_HELD: begin
              if (flags.gt_a) begin
                wr.fall_we = 1'b1;
                phase_d    = PH_RELEASED;
              end
            end
            PH_RELEASED: ;
          endcase
        end else begin
          if (phase_q == PH_HELD) begin
            wr.fall_we = 1'b1;
          end
          phase_d = PH_START;
        end
        state_d = ST_CLASSIFY;
        idx_d   = '0;
      end

      // press duration = fall - rise; stale or short presses stay put
      ST_CLASSIFY: begin
        alu_a = fall_rd;
        alu_b = rise_rd;
        if (rise_rd != '0 && fall_rd != '0 && !flags.neg && flags.gt_a) begin
          acc_d[idx_q] = flags.lt_b ? RES_TAP : RES_HOLD;
          wr.rise_we   = 1'b1;
          wr.rise_clr  = 1'b1;
          wr.fall_we   = 1'b1;
          wr.fall_clr  = 1'b1;
        end
        state_d = ST_RELEASE;
      end

      // forced fall once the last rise is auto_release_ms old
      ST_RELEASE: begin
        alu_b = rel_rd;
        thr_b = auto_q;
        if (!flags.lt_b) begin
          wr.fall_we = 1'b1;
        end
        if (last_key) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CLASSIFY;
        end
      end

      // hand over once the output register is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          res_d       = acc_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign state_key0_o = res_q[0];
  assign state_key1_o = res_q[1];
  assign state_key2_o = res_q[2];
  assign state_key3_o = res_q[3];
  assign state_key4_o = res_q[4];

`ifndef SYNTHESIS
  // held is reachable only through debounce
  a_held_via_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HELD && $past(phase_q) != PH_HELD) |-> $past(phase_q) == PH_DEBOUNCE)
    else $error("key 4 reached held without debounce");

  // a level-change request never produces a result
  a_event_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_i == REQ_EVENT && !out_valid_o) |=> !out_valid_o)
    else $error("result raised by a level-change request");

  // the walk never touches a key beyond KEY_COUNT
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLASSIFY || state_q == ST_RELEASE) |-> key_ok)
    else $error("key index out of range during walk");

  // absent key 4 always reports none
  a_absent_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && KEY_COUNT < MAX_KEYS) |-> state_key4_o == RES_NONE)
    else $error("result for an absent key");

  // no undefined result code
  a_res_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_key0_o != 2'd3 && state_key1_o != 2'd3 && state_key2_o != 2'd3
                     && state_key3_o != 2'd3 && state_key4_o != 2'd3))
    else $error("illegal result code");
`endif

endmodule
